// File: hdl/wsr_pkg.sv
// shared types and constants of the wilkes square root block
`timescale 1ns / 1ps

package wsr_pkg;

   // fixed field widths
   localparam int X_BITS     = 32;
   localparam int EPS_BITS   = 21;
   localparam int LIM_BITS   = 6;
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 32;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_EPSILON = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT   = 4'd1;

   // register reset values
   localparam logic [EPS_BITS-1:0] EPS_RESET = 21'd1;
   localparam logic [LIM_BITS-1:0] LIM_RESET = 6'd40;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AC_GO,
      ST_AC_WAIT,
      ST_CC_GO,
      ST_CC_WAIT,
      ST_CT_GO,
      ST_CT_WAIT,
      ST_CHECK
   } state_type;

   // right shift applied to a product magnitude
   typedef enum logic [1:0] {
      SHIFT_F,
      SHIFT_F1,
      SHIFT_F2
   } shift_type;

   // request from the sequencer to the multiplier
   typedef struct packed {
      logic      start;
      shift_type shift;
   } mul_ctrl_type;

endpackage

// File: hdl/wsr_mul.sv
// shift-and-add multiplier, one multiplier bit per cycle, with scaling and saturation
`timescale 1ns / 1ps

module wsr_mul #(
   parameter int FRACTION_BITS = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wsr_pkg::mul_ctrl_type         ctrl,
   input  logic signed [FRACTION_BITS+3:0] op_a,
   input  logic signed [FRACTION_BITS+3:0] op_b,
   output logic                          done,
   output logic signed [FRACTION_BITS+3:0] result,
   output logic        [FRACTION_BITS+2:0] result_mag
);

   localparam int W    = FRACTION_BITS + 4;
   localparam int M    = FRACTION_BITS + 3;
   localparam int PW   = 2 * M;
   localparam int CNTW = $clog2(M);

   logic                  run_ff;
   logic                  fin_ff;
   logic                  done_ff;
   logic [CNTW-1:0]       cnt_ff;
   logic [M-1:0]          mcand_ff;
   logic [PW-1:0]         prod_ff;
   logic                  neg_ff;
   wsr_pkg::shift_type    shift_ff;
   logic signed [W-1:0]   result_ff;
   logic [M-1:0]          mag_ff;

   logic [W-1:0]          abs_a;
   logic [W-1:0]          abs_b;
   logic [M:0]            sum;
   logic                  ovf;
   logic [M-1:0]          q;
   logic [M-1:0]          q_sat;

   // operands never exceed the saturation bound, so magnitudes fit m bits
   assign abs_a = op_a[W-1] ? -op_a : op_a;
   assign abs_b = op_b[W-1] ? -op_b : op_b;

   assign sum = {1'b0, prod_ff[PW-1:M]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      unique case (shift_ff)
         wsr_pkg::SHIFT_F1: begin
            ovf = |prod_ff[PW-1:M+FRACTION_BITS+1];
            q   = prod_ff[M+FRACTION_BITS:FRACTION_BITS+1];
         end
         wsr_pkg::SHIFT_F2: begin
            ovf = |prod_ff[PW-1:M+FRACTION_BITS+2];
            q   = prod_ff[M+FRACTION_BITS+1:FRACTION_BITS+2];
         end
         default: begin
            ovf = |prod_ff[PW-1:M+FRACTION_BITS];
            q   = prod_ff[M+FRACTION_BITS-1:FRACTION_BITS];
         end
      endcase
      q_sat = ovf ? '1 : q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= run_ff && (cnt_ff == CNTW'(M - 1));
         if (ctrl.start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (cnt_ff == CNTW'(M - 1))) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         mcand_ff <= abs_a[M-1:0];
         prod_ff  <= {{M{1'b0}}, abs_b[M-1:0]};
         neg_ff   <= op_a[W-1] ^ op_b[W-1];
         shift_ff <= ctrl.shift;
         cnt_ff   <= '0;
      end else if (run_ff) begin
         prod_ff <= {sum, prod_ff[M-1:1]};
         cnt_ff  <= cnt_ff + CNTW'(1);
      end
      if (fin_ff) begin
         mag_ff    <= q_sat;
         result_ff <= neg_ff ? -signed'(W'(q_sat)) : signed'(W'(q_sat));
      end
   end

   assign done       = done_ff;
   assign result     = result_ff;
   assign result_mag = mag_ff;

endmodule

// File: hdl/wilkes_square_root.sv
// top level of the wilkes square root block: registers, sequencer and result port
`timescale 1ns / 1ps

// Wilkes-Wheeler-Gill square root of one unsigned Q2.F operand (F = FRACTION_BITS),
// result in the same format. An item is taken when start is high and busy is low;
// for an operand in range busy then stays high until the result has been produced.
// Each result appears on the rsp_ ports for one cycle with rsp_valid high and must
// be taken then: the receiver cannot stall the block. An operand of zero or of three
// or more is answered the cycle after it is taken with rsp_range_error set and the
// operand returned as the root, and busy stays low. Otherwise the result strobe comes
// after n iterations of the loop, n being the iteration count (1 .. iteration_limit),
// and the next item can be taken in the same cycle as that strobe. The pace is set by
// the single shift-and-add multiplier, which retires one multiplier bit per cycle (F+3
// bits, plus launch, scaling and hand-back for each product) and serves the three
// dependent products of each iteration in turn; a check state in each iteration makes
// the stop test. No clearing pass follows reset. Registers: index 0 epsilon_lsbs (21
// bits, reset 1), index 1 iteration_limit (6 bits, reset 40, zero acts as one); other
// indexes are ignored.

module wilkes_square_root #(
   parameter int FRACTION_BITS = 30
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [wsr_pkg::X_BITS-1:0]         req_x_value,
   output logic                               rsp_valid,
   output logic [wsr_pkg::X_BITS-1:0]         rsp_root,
   output logic [wsr_pkg::LIM_BITS-1:0]       rsp_iteration_count,
   output logic                               rsp_range_error,
   output logic                               rsp_limit_reached,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wsr_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [wsr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // working words are signed q3.f, magnitudes q2.f plus one bit
   localparam int W  = FRACTION_BITS + 4;
   localparam int M  = FRACTION_BITS + 3;
   localparam int CW = (M > wsr_pkg::EPS_BITS) ? M : wsr_pkg::EPS_BITS;
   localparam int XW = (W > 34) ? W : 34;

   localparam logic signed [W:0] WORK_MAX_E =
      signed'({2'b00, {(W-1){1'b1}}});
   localparam logic signed [W:0] THREE_E =
      signed'({{(W-1-FRACTION_BITS){1'b0}}, 2'b11, {FRACTION_BITS{1'b0}}});
   localparam logic signed [W-1:0] ONE_Q =
      signed'({{(W-1-FRACTION_BITS){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}});
   localparam logic [63:0] THREE_X = 64'd3 << FRACTION_BITS;

   // configuration registers
   logic [wsr_pkg::EPS_BITS-1:0] eps_ff;
   logic [wsr_pkg::LIM_BITS-1:0] lim_ff;

   // sequencer
   wsr_pkg::state_type state_ff;
   wsr_pkg::state_type state_in;

   // working values
   logic signed [W-1:0]          a_ff;
   logic signed [W-1:0]          c_ff;
   logic signed [W-1:0]          sq_ff;
   logic signed [W-1:0]          t_ff;
   logic [wsr_pkg::LIM_BITS-1:0] step_ff;

   // result register
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [wsr_pkg::X_BITS-1:0]   rsp_root_ff;
   logic [wsr_pkg::LIM_BITS-1:0] rsp_count_ff;
   logic                         rsp_err_ff;
   logic                         rsp_lim_ff;

   // multiplier hookup
   wsr_pkg::mul_ctrl_type        mul_ctrl;
   logic signed [W-1:0]          mul_a;
   logic signed [W-1:0]          mul_b;
   logic                         mul_done;
   logic signed [W-1:0]          mul_result;
   logic [M-1:0]                 mul_mag;

   // decisions
   logic                         accept;
   logic                         x_bad;
   logic                         converged;
   logic                         at_limit;
   logic                         finish;
   logic [wsr_pkg::LIM_BITS-1:0] lim_eff;
   logic signed [XW-1:0]         a_ext;
   logic [wsr_pkg::X_BITS-1:0]   root_clamp;

   // subtract result clamped to +-(2^(f+3) - 1)
   function automatic logic signed [W-1:0] sat_work(input logic signed [W:0] v);
      logic signed [W:0] r;
      r = v;
      if (v > WORK_MAX_E) begin
         r = WORK_MAX_E;
      end else if (v < -WORK_MAX_E) begin
         r = -WORK_MAX_E;
      end
      return signed'(r[W-1:0]);
   endfunction

   assign csr_ready = 1'b1;

   // register writes; unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= wsr_pkg::EPS_RESET;
         lim_ff <= wsr_pkg::LIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wsr_pkg::CSR_EPSILON: eps_ff <= csr_wdata[wsr_pkg::EPS_BITS-1:0];
            wsr_pkg::CSR_LIMIT:   lim_ff <= csr_wdata[wsr_pkg::LIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign accept = start && !busy;

   // operand must lie strictly between zero and three
   assign x_bad = (req_x_value == '0) ||
                  ({{(64-wsr_pkg::X_BITS){1'b0}}, req_x_value} >= THREE_X);

   // stop tests, valid in the check state once the new c is in place
   assign lim_eff   = (lim_ff == '0) ? wsr_pkg::LIM_BITS'(1) : lim_ff;
   assign converged = CW'(mul_mag) < CW'(eps_ff);
   assign at_limit  = step_ff >= lim_eff;
   assign finish    = converged || at_limit;

   // root clamped into the unsigned output range
   assign a_ext = XW'(a_ff);
   always_comb begin
      if (a_ext[XW-1]) begin
         root_clamp = '0;
      end else if (|a_ext[XW-2:wsr_pkg::X_BITS]) begin
         root_clamp = '1;
      end else begin
         root_clamp = a_ext[wsr_pkg::X_BITS-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wsr_pkg::ST_IDLE:    if (accept && !x_bad) state_in = wsr_pkg::ST_AC_GO;
         wsr_pkg::ST_AC_GO:   state_in = wsr_pkg::ST_AC_WAIT;
         wsr_pkg::ST_AC_WAIT: if (mul_done) state_in = wsr_pkg::ST_CC_GO;
         wsr_pkg::ST_CC_GO:   state_in = wsr_pkg::ST_CC_WAIT;
         wsr_pkg::ST_CC_WAIT: if (mul_done) state_in = wsr_pkg::ST_CT_GO;
         wsr_pkg::ST_CT_GO:   state_in = wsr_pkg::ST_CT_WAIT;
         wsr_pkg::ST_CT_WAIT: if (mul_done) state_in = wsr_pkg::ST_CHECK;
         wsr_pkg::ST_CHECK:   state_in = finish ? wsr_pkg::ST_IDLE : wsr_pkg::ST_AC_GO;
      endcase
   end

   // sequencer outputs: multiplier launches and the result strobe
   always_comb begin
      busy           = (state_ff != wsr_pkg::ST_IDLE);
      mul_ctrl.start = 1'b0;
      mul_ctrl.shift = wsr_pkg::SHIFT_F;
      mul_a          = a_ff;
      mul_b          = c_ff;
      rsp_valid_in   = 1'b0;
      unique case (state_ff)
         wsr_pkg::ST_IDLE: begin
            rsp_valid_in = accept && x_bad;
         end
         // root * c / 2
         wsr_pkg::ST_AC_GO: begin
            mul_ctrl.start = 1'b1;
            mul_ctrl.shift = wsr_pkg::SHIFT_F1;
         end
         // c * c, still the old c
         wsr_pkg::ST_CC_GO: begin
            mul_ctrl.start = 1'b1;
            mul_a          = c_ff;
         end
         // c^2 * (c - 3) / 4
         wsr_pkg::ST_CT_GO: begin
            mul_ctrl.start = 1'b1;
            mul_ctrl.shift = wsr_pkg::SHIFT_F2;
            mul_a          = sq_ff;
            mul_b          = t_ff;
         end
         wsr_pkg::ST_CHECK: begin
            rsp_valid_in = finish;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         wsr_pkg::ST_IDLE: begin
            if (accept) begin
               a_ff    <= W'(req_x_value);
               step_ff <= '0;
               if (x_bad) begin
                  c_ff         <= '0;
                  rsp_root_ff  <= req_x_value;
                  rsp_count_ff <= '0;
                  rsp_err_ff   <= 1'b1;
                  rsp_lim_ff   <= 1'b0;
               end else begin
                  c_ff <= W'(req_x_value) - ONE_Q;
               end
            end
         end
         wsr_pkg::ST_AC_WAIT: begin
            if (mul_done) a_ff <= sat_work((W+1)'(a_ff) - (W+1)'(mul_result));
         end
         wsr_pkg::ST_CC_GO: begin
            t_ff <= sat_work((W+1)'(c_ff) - THREE_E);
         end
         wsr_pkg::ST_CC_WAIT: begin
            if (mul_done) sq_ff <= mul_result;
         end
         wsr_pkg::ST_CT_WAIT: begin
            if (mul_done) begin
               c_ff    <= mul_result;
               step_ff <= step_ff + wsr_pkg::LIM_BITS'(1);
            end
         end
         wsr_pkg::ST_CHECK: begin
            if (finish) begin
               rsp_root_ff  <= root_clamp;
               rsp_count_ff <= step_ff;
               rsp_err_ff   <= 1'b0;
               // converging on the last allowed pass is not a limit stop
               rsp_lim_ff   <= !converged;
            end
         end
         default: ;
      endcase
   end

   wsr_mul #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_mul (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mul_ctrl),
      .op_a       (mul_a),
      .op_b       (mul_b),
      .done       (mul_done),
      .result     (mul_result),
      .result_mag (mul_mag)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_root            = rsp_root_ff;
   assign rsp_iteration_count = rsp_count_ff;
   assign rsp_range_error     = rsp_err_ff;
   assign rsp_limit_reached   = rsp_lim_ff;

endmodule

// File: hdl/wsr_checker.sv
// port-level assertions for the wilkes square root block and their bind
`timescale 1ns / 1ps

module wsr_checker #(
   parameter int FRACTION_BITS = 30
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [wsr_pkg::X_BITS-1:0]   req_x_value,
   input logic                         rsp_valid,
   input logic [wsr_pkg::X_BITS-1:0]   rsp_root,
   input logic [wsr_pkg::LIM_BITS-1:0] rsp_iteration_count,
   input logic                         rsp_range_error,
   input logic                         rsp_limit_reached
);

   localparam logic [63:0] THREE_X = 64'd3 << FRACTION_BITS;

   logic x_bad;
   assign x_bad = (req_x_value == '0) ||
                  ({{(64-wsr_pkg::X_BITS){1'b0}}, req_x_value} >= THREE_X);

   // a refused operand comes straight back with no iterations
   a_bad_echo: assert property (@(posedge clock) disable iff (reset)
      start && !busy && x_bad |=>
         rsp_valid && rsp_range_error && (rsp_root == $past(req_x_value)))
      else $error("range error item not echoed");

   // a valid operand occupies the block
   a_good_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !x_bad |=> busy && !rsp_valid)
      else $error("valid item did not start iterating");

   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> (rsp_iteration_count == '0) && !rsp_limit_reached)
      else $error("range error with iterations or limit flag");

   a_runs_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_range_error |-> rsp_iteration_count != '0)
      else $error("result without any iteration");

endmodule

bind wilkes_square_root wsr_checker #(
   .FRACTION_BITS(FRACTION_BITS)
) u_wsr_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_x_value         (req_x_value),
   .rsp_valid           (rsp_valid),
   .rsp_root            (rsp_root),
   .rsp_iteration_count (rsp_iteration_count),
   .rsp_range_error     (rsp_range_error),
   .rsp_limit_reached   (rsp_limit_reached)
);
